[hw/rtl/prtl_pkg.sv]
package prtl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int PORT_W      = 8;
  localparam int HOP_W       = 32;
  localparam int METRIC_W    = 8;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  // input mode codes
  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_INSERT,
    OP_DELETE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // one decoded request between front and engine
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   key;     // raw address on query, masked prefix otherwise
    logic [LEN_W-1:0]    len;     // saturated to 32
    logic [PORT_W-1:0]   port;
    logic [HOP_W-1:0]    hop;
    logic [METRIC_W-1:0] metric;
  } cmd_t;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [LEN_W-1:0]    len;
    logic [PORT_W-1:0]   port;
    logic [HOP_W-1:0]    hop;
    logic [METRIC_W-1:0] metric;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [ADDR_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= MAX_LEN) begin
      m = '1;
    end else begin
      m = (ADDR_W'(1) << len) - ADDR_W'(1);
    end
    return m;
  endfunction

endpackage

[hw/rtl/prtl_ram.sv]
module prtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/prtl_front.sv]
module prtl_front
  import prtl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [ADDR_W-1:0]   address,
  input  logic [LEN_W-1:0]    prefix_len,
  input  logic [PORT_W-1:0]   port_in,
  input  logic [HOP_W-1:0]    hop_in,
  input  logic [METRIC_W-1:0] metric_in,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_pop
);

  // two-entry request queue
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       dec;
  logic [LEN_W-1:0] sat_len;

  // classify: saturate length, mask prefix for updates
  always_comb begin
    sat_len = (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
    unique case (mode)
      MODE_INSERT: dec.op = OP_INSERT;
      MODE_DELETE: dec.op = OP_DELETE;
      default:     dec.op = OP_QUERY;
    endcase
    dec.key    = (dec.op == OP_QUERY) ? address : (address & low_mask(sat_len));
    dec.len    = sat_len;
    dec.port   = port_in;
    dec.hop    = hop_in;
    dec.metric = metric_in;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/prtl_engine.sv]
module prtl_engine
  import prtl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  input  logic                res_pop,
  output status_t             res_status,
  output logic [HOP_W-1:0]    res_hop,
  output logic [PORT_W-1:0]   res_port,
  output logic [METRIC_W-1:0] res_metric
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t                   state;
  cmd_t                     cur;
  logic [TABLE_DEPTH-1:0]   valid;
  logic [IDX_W-1:0]         rd_idx;
  logic                     issuing;
  logic                     eval_v;
  logic [IDX_W-1:0]         eval_idx;

  logic                     exact_found;
  logic [IDX_W-1:0]         exact_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic                     best_found;
  logic [LEN_W-1:0]         best_len;
  logic [HOP_W-1:0]         best_hop;
  logic [PORT_W-1:0]        best_port;
  logic [METRIC_W-1:0]      best_metric;

  entry_t                   rd_ent;
  logic [ENTRY_W-1:0]       rd_raw;
  logic                     ent_v;
  logic                     hit_exact;
  logic                     hit_query;
  logic                     can_load;
  logic                     ins_ok;
  logic                     ram_we;
  logic [IDX_W-1:0]         wr_idx;
  entry_t                   wr_ent;

  status_t                  fin_status;
  logic [HOP_W-1:0]         fin_hop;
  logic [PORT_W-1:0]        fin_port;
  logic [METRIC_W-1:0]      fin_metric;

  prtl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .raddr (rd_idx),
    .rdata (rd_raw)
  );

  always_comb begin
    rd_ent    = entry_t'(rd_raw);
    ent_v     = eval_v && valid[eval_idx];
    hit_exact = ent_v && (rd_ent.len == cur.len) && (rd_ent.prefix == cur.key);
    hit_query = ent_v && (!best_found || (rd_ent.len > best_len)) &&
                ((cur.key & low_mask(rd_ent.len)) == rd_ent.prefix);
    can_load  = !res_valid || res_pop;
    ins_ok    = exact_found || free_found;
    wr_idx    = exact_found ? exact_idx : free_idx;
    wr_ent.prefix = cur.key;
    wr_ent.len    = cur.len;
    wr_ent.port   = cur.port;
    wr_ent.hop    = cur.hop;
    wr_ent.metric = cur.metric;
    ram_we    = (state == S_FINISH) && can_load && (cur.op == OP_INSERT) && ins_ok;
    cmd_pop   = (state == S_IDLE) && cmd_valid;
  end

  // result of the finished walk
  always_comb begin
    fin_status = ST_DONE;
    fin_hop    = '0;
    fin_port   = '0;
    fin_metric = '0;
    unique case (cur.op)
      OP_INSERT: begin
        if (!ins_ok) begin
          fin_status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (!exact_found) begin
          fin_status = ST_MISS;
        end
      end
      default: begin
        if (best_found) begin
          fin_hop    = best_hop;
          fin_port   = best_port;
          fin_metric = best_metric;
        end else begin
          fin_status = ST_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
      issuing   <= 1'b0;
      eval_v    <= 1'b0;
    end else begin
      if ((state == S_FINISH) && can_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur         <= cmd;
            rd_idx      <= '0;
            issuing     <= 1'b1;
            eval_v      <= 1'b0;
            exact_found <= 1'b0;
            free_found  <= 1'b0;
            best_found  <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // walk the table: address out one cycle, entry judged the next
          if (issuing) begin
            rd_idx <= rd_idx + IDX_W'(1);
            if (rd_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          eval_v   <= issuing;
          eval_idx <= rd_idx;
          if (eval_v) begin
            if (hit_exact && !exact_found) begin
              exact_found <= 1'b1;
              exact_idx   <= eval_idx;
            end
            if (!valid[eval_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= eval_idx;
            end
            if (hit_query) begin
              best_found  <= 1'b1;
              best_len    <= rd_ent.len;
              best_hop    <= rd_ent.hop;
              best_port   <= rd_ent.port;
              best_metric <= rd_ent.metric;
            end
            if (eval_idx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // commit the update and the result together once the slot is free
          if (can_load) begin
            res_status <= fin_status;
            res_hop    <= fin_hop;
            res_port   <= fin_port;
            res_metric <= fin_metric;
            unique case (cur.op)
              OP_INSERT: begin
                if (ins_ok) begin
                  valid[wr_idx] <= 1'b1;
                end
              end
              OP_DELETE: begin
                if (exact_found) begin
                  valid[exact_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/prefix_route_table_lpm.sv]
// IPv4 longest-prefix-match routing table of TABLE_DEPTH (64) routes. Push a
// request (mode 0 query, 1 insert or replace, 2 delete; mode 3 acts as a
// query) and pop exactly one result per request, in order. A prefix of
// length L sits in the low L bits of the address word, lengths above
// 32 count as 32, and a length-0 route is a default route matching every
// address. Every request walks the whole route memory once, one slot per
// cycle through its single read port, and the engine takes no new request
// until the result of the last one is loaded. A two-entry request queue
// takes new requests while the engine works, and a one-entry result
// register lets the engine finish the next walk while a result waits.
// Insert fills the lowest free slot unless an equal route exists; with no
// free slot it returns status 2 and leaves the table alone. Delete and query
// misses return status 1 and zeros. No clearing pass is needed after reset:
// per-slot valid bits start cleared.
module prefix_route_table_lpm
  import prtl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request side
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [ADDR_W-1:0]   address,
  input  logic [LEN_W-1:0]    prefix_len,
  input  logic [PORT_W-1:0]   port_in,
  input  logic [HOP_W-1:0]    hop_in,
  input  logic [METRIC_W-1:0] metric_in,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status,
  output logic [HOP_W-1:0]    hop_out,
  output logic [PORT_W-1:0]   port_out,
  output logic [METRIC_W-1:0] metric_out
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_valid;
  status_t res_status;

  // front: decode mode, saturate length, mask prefix, queue the request
  prtl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .address    (address),
    .prefix_len (prefix_len),
    .port_in    (port_in),
    .hop_in     (hop_in),
    .metric_in  (metric_in),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // back: walk the route memory, then commit the update and hold the result
  prtl_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_status (res_status),
    .res_hop    (hop_out),
    .res_port   (port_out),
    .res_metric (metric_out)
  );

  assign empty  = !res_valid;
  assign status = res_status;

endmodule
